@@ hdl/ffra_pkg.sv @@
// Shared constants and types for the first-fit run allocator.
package ffra_pkg;

  localparam int MAX_POS   = 1024;
  localparam int POS_W     = 10;
  localparam int LEN_W     = 11;
  localparam int WORD_W    = 8;
  localparam int BIT_W     = 3;
  localparam int NUM_WORDS = MAX_POS / WORD_W;
  localparam int ADDR_W    = 7;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CLAIM = 1'b1;

  localparam logic [LEN_W-1:0] SIZE_RESET = LEN_W'(MAX_POS);

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_LD_RD   = 8'b0000_0100,
    ST_LD_WR   = 8'b0000_1000,
    ST_SCAN    = 8'b0001_0000,
    ST_FLIP_RD = 8'b0010_0000,
    ST_FLIP_WR = 8'b0100_0000,
    ST_RESP    = 8'b1000_0000
  } state_t;

  // Running state of the first-fit scan, carried from one word to the next.
  typedef struct packed {
    logic             hit;
    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] start;
  } scan_t;

endpackage

@@ hdl/ffra_ifs.sv @@
// Valid/ready channel interfaces for claim/load items and result items.
interface ffra_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [ffra_pkg::POS_W-1:0] position;
  logic                      bit_kind;
  logic [ffra_pkg::LEN_W-1:0] request_length;
  modport source(output valid, operation, position, bit_kind, request_length, input ready);
  modport sink(input valid, operation, position, bit_kind, request_length, output ready);
endinterface

interface ffra_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [ffra_pkg::POS_W-1:0] start_position;
  modport source(output valid, found, start_position, input ready);
  modport sink(input valid, found, start_position, output ready);
endinterface

@@ hdl/ffra_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/ffra_word_scan.sv @@
// Advances the first-fit run search across one bitmap word.
module ffra_word_scan (
  input  logic [ffra_pkg::WORD_W-1:0] data,
  input  logic [ffra_pkg::ADDR_W-1:0] word_idx,
  input  logic [ffra_pkg::LEN_W-1:0]  n_eff,
  input  logic                        kind,
  input  logic [ffra_pkg::LEN_W-1:0]  req_len,
  input  ffra_pkg::scan_t             scan_in,
  output ffra_pkg::scan_t             scan_out
);

  always_comb begin
    logic [ffra_pkg::POS_W-1:0] g;
    logic                       same;
    scan_out = scan_in;
    for (int b = 0; b < ffra_pkg::WORD_W; b++) begin
      g    = {word_idx, ffra_pkg::BIT_W'(b)};
      same = ({1'b0, g} < n_eff) && (data[b] == kind);
      // The first run to reach the requested length is the leftmost fitting run.
      if (!scan_out.hit) begin
        if (same) begin
          if (scan_out.len == '0) begin
            scan_out.start = g;
          end
          scan_out.len = scan_out.len + 1'b1;
          if (scan_out.len == req_len) begin
            scan_out.hit = 1'b1;
          end
        end else begin
          scan_out.len = '0;
        end
      end
    end
  end

endmodule

@@ hdl/first_fit_run_allocator_core.sv @@
// First-fit run allocator: bitmap in one word RAM, word-serial scan and flip.
// The bitmap lives in a 128 x 8-bit RAM. After reset a clearing pass over all 128
// words zeroes it, during which no item is accepted. A load item reads, modifies
// and writes back one word. A claim scans one word per cycle from word 0
// through the word holding the last active position, stopping at the first run
// that reaches the requested length; it then reads and rewrites each word
// covering the flipped bits. One item is in work at a time; a result waits in
// an output register.
module first_fit_run_allocator_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ffra_pkg::LEN_W-1:0] cfg_wdata,
  ffra_in_if.sink                    in_ch,
  ffra_out_if.source                 out_ch
);

  localparam int AW = ffra_pkg::ADDR_W;
  localparam int LW = ffra_pkg::LEN_W;
  localparam int PW = ffra_pkg::POS_W;
  localparam int WW = ffra_pkg::WORD_W;

  ffra_pkg::state_t state_r, state_nxt;
  logic [LW-1:0] size_r, size_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic          issue_r, issue_nxt;
  logic          proc_valid_r, proc_valid_nxt;
  logic [AW-1:0] proc_addr_r, proc_addr_nxt;
  ffra_pkg::scan_t scan_r, scan_nxt, scan_res;
  logic          kind_r, kind_nxt;
  logic [LW-1:0] k_r, k_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [LW-1:0] end_r, end_nxt;
  logic          res_found_r, res_found_nxt;
  logic [PW-1:0] res_start_r, res_start_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_found_r, out_found_nxt;
  logic [PW-1:0] out_start_r, out_start_nxt;

  logic [LW-1:0] n_eff;
  logic [LW-1:0] n_m1;
  logic [LW-1:0] end_new;
  logic [LW-1:0] end_m1;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WW-1:0] ram_wdata, ram_rdata;
  logic [WW-1:0] flip_mask;

  assign n_eff   = (size_r > ffra_pkg::SIZE_RESET) ? ffra_pkg::SIZE_RESET : size_r;
  assign n_m1    = n_eff - 1'b1;
  assign end_new = LW'(scan_res.start) + k_r;
  assign end_m1  = end_r - 1'b1;

  ffra_ram #(.WIDTH(WW), .DEPTH(ffra_pkg::NUM_WORDS)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ffra_word_scan u_scan (
    .data    (ram_rdata),
    .word_idx(proc_addr_r),
    .n_eff   (n_eff),
    .kind    (kind_r),
    .req_len (k_r),
    .scan_in (scan_r),
    .scan_out(scan_res)
  );

  always_comb begin
    logic [LW-1:0] g;
    for (int b = 0; b < WW; b++) begin
      g = {1'b0, addr_r, ffra_pkg::BIT_W'(b)};
      flip_mask[b] = (g >= LW'(scan_r.start)) && (g < end_r);
    end
  end

  assign in_ch.ready           = (state_r == ffra_pkg::ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.start_position = out_start_r;

  always_comb begin
    state_nxt      = state_r;
    size_nxt       = cfg_we ? cfg_wdata : size_r;
    addr_nxt       = addr_r;
    last_nxt       = last_r;
    issue_nxt      = issue_r;
    proc_valid_nxt = 1'b0;
    proc_addr_nxt  = proc_addr_r;
    scan_nxt       = scan_r;
    kind_nxt       = kind_r;
    k_nxt          = k_r;
    pos_nxt        = pos_r;
    end_nxt        = end_r;
    res_found_nxt  = res_found_r;
    res_start_nxt  = res_start_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_found_nxt  = out_found_r;
    out_start_nxt  = out_start_r;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = '0;
    ram_raddr      = addr_r;

    unique case (state_r)
      ffra_pkg::ST_CLEAR: begin
        ram_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == AW'(ffra_pkg::NUM_WORDS - 1)) begin
          state_nxt = ffra_pkg::ST_IDLE;
        end
      end
      ffra_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt = in_ch.bit_kind;
          k_nxt    = in_ch.request_length;
          pos_nxt  = in_ch.position;
          if (in_ch.operation == ffra_pkg::OP_LOAD) begin
            addr_nxt  = in_ch.position[PW-1:ffra_pkg::BIT_W];
            state_nxt = ffra_pkg::ST_LD_RD;
          end else if (in_ch.request_length == '0 || n_eff == '0) begin
            res_found_nxt = 1'b0;
            res_start_nxt = '0;
            state_nxt     = ffra_pkg::ST_RESP;
          end else begin
            addr_nxt  = '0;
            last_nxt  = n_m1[PW-1:ffra_pkg::BIT_W];
            issue_nxt = 1'b1;
            scan_nxt  = '0;
            state_nxt = ffra_pkg::ST_SCAN;
          end
        end
      end
      ffra_pkg::ST_LD_RD: begin
        state_nxt = ffra_pkg::ST_LD_WR;
      end
      ffra_pkg::ST_LD_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        ram_wdata[pos_r[ffra_pkg::BIT_W-1:0]] = kind_r;
        state_nxt = ffra_pkg::ST_IDLE;
      end
      ffra_pkg::ST_SCAN: begin
        // Reads stream one word a cycle; the word read last cycle is evaluated now.
        if (issue_r) begin
          proc_valid_nxt = 1'b1;
          proc_addr_nxt  = addr_r;
          addr_nxt       = addr_r + 1'b1;
          issue_nxt      = (addr_r != last_r);
        end
        if (proc_valid_r) begin
          scan_nxt = scan_res;
          if (scan_res.hit) begin
            proc_valid_nxt = 1'b0;
            end_nxt        = end_new;
            addr_nxt       = scan_res.start[PW-1:ffra_pkg::BIT_W];
            last_nxt       = AW'((end_new - 1'b1) >> ffra_pkg::BIT_W);
            res_found_nxt  = 1'b1;
            res_start_nxt  = scan_res.start;
            state_nxt      = ffra_pkg::ST_FLIP_RD;
          end else if (proc_addr_r == last_r) begin
            res_found_nxt = 1'b0;
            res_start_nxt = '0;
            state_nxt     = ffra_pkg::ST_RESP;
          end
        end
      end
      ffra_pkg::ST_FLIP_RD: begin
        state_nxt = ffra_pkg::ST_FLIP_WR;
      end
      ffra_pkg::ST_FLIP_WR: begin
        ram_we    = 1'b1;
        ram_wdata = kind_r ? (ram_rdata & ~flip_mask) : (ram_rdata | flip_mask);
        if (addr_r == end_m1[PW-1:ffra_pkg::BIT_W]) begin
          state_nxt = ffra_pkg::ST_RESP;
        end else begin
          addr_nxt  = addr_r + 1'b1;
          state_nxt = ffra_pkg::ST_FLIP_RD;
        end
      end
      ffra_pkg::ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_start_nxt = res_start_r;
          state_nxt     = ffra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ffra_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ffra_pkg::ST_CLEAR;
      size_r       <= ffra_pkg::SIZE_RESET;
      addr_r       <= '0;
      issue_r      <= 1'b0;
      proc_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      size_r       <= size_nxt;
      addr_r       <= addr_nxt;
      issue_r      <= issue_nxt;
      proc_valid_r <= proc_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    proc_addr_r <= proc_addr_nxt;
    scan_r      <= scan_nxt;
    kind_r      <= kind_nxt;
    k_r         <= k_nxt;
    pos_r       <= pos_nxt;
    end_r       <= end_nxt;
    res_found_r <= res_found_nxt;
    res_start_r <= res_start_nxt;
    out_found_r <= out_found_nxt;
    out_start_r <= out_start_nxt;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == ffra_pkg::ST_IDLE)
    else $error("input ready outside idle");

  a_proc_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    proc_valid_r |-> state_r == ffra_pkg::ST_SCAN)
    else $error("word evaluated outside scan");

  a_flip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffra_pkg::ST_FLIP_WR) |-> (end_r <= ffra_pkg::SIZE_RESET && end_r != '0))
    else $error("flip range beyond bitmap");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ffra_pkg::ST_CLEAR || state_r == ffra_pkg::ST_LD_WR ||
                state_r == ffra_pkg::ST_FLIP_WR))
    else $error("bitmap write in wrong state");

endmodule

@@ tb/tb_ifs_note.sv @@
// Testbench-side helper types for driving the allocator channels.
`timescale 1ns / 100ps
package tb_ffra_types;

  // One row of stimulus: a load or claim item, with an optional typed-in answer.
  typedef struct {
    logic                       op;
    logic [ffra_pkg::POS_W-1:0] pos;
    logic                       kind;
    logic [ffra_pkg::LEN_W-1:0] len;
    bit                         fixed;
    logic                       fixed_found;
    logic [ffra_pkg::POS_W-1:0] fixed_start;
  } stim_row_t;

  typedef struct packed {
    logic                       found;
    logic [ffra_pkg::POS_W-1:0] start;
  } claim_ans_t;
endpackage

@@ tb/tb_top.sv @@
// Self-checking testbench for the first-fit run allocator core.
`timescale 1ns / 100ps
module tb_top;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int N_RANDOM    = 830;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ffra_pkg::LEN_W-1:0] cfg_wdata;

  ffra_in_if  in_ch();
  ffra_out_if out_ch();

  first_fit_run_allocator_core DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Shadow of the block's state.
  logic                       shadow_map [ffra_pkg::MAX_POS];
  logic [ffra_pkg::LEN_W-1:0] shadow_size;

  tb_ffra_types::claim_ans_t pending_answers[$];
  int errors;
  int claims_checked;
  int claims_found;
  int cycles = 0;
  bit hold_off;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // First-fit search over the active positions; flips the claimed bits.
  function automatic tb_ffra_types::claim_ans_t first_fit_claim(
      input logic kind, input logic [ffra_pkg::LEN_W-1:0] len);
    tb_ffra_types::claim_ans_t ans;
    int n;
    int run_start;
    bit in_run;
    bit same;
    ans = '0;
    if (len == 0) return ans;
    n = (shadow_size > ffra_pkg::MAX_POS) ? ffra_pkg::MAX_POS : int'(shadow_size);
    in_run = 0;
    run_start = 0;
    for (int i = 0; i <= n; i++) begin
      same = (i < n) && (shadow_map[i] == kind);
      if (same) begin
        if (!in_run) begin
          in_run = 1;
          run_start = i;
        end
      end else if (in_run) begin
        in_run = 0;
        if (i - run_start >= int'(len)) begin
          for (int j = run_start; j < run_start + int'(len); j++) shadow_map[j] = ~kind;
          ans.found = 1'b1;
          ans.start = ffra_pkg::POS_W'(run_start);
          return ans;
        end
      end
    end
    return ans;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("** first_fit_run_allocator_core: FAILED **");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off when asked.
  initial begin
    int wait_cycles;
    tb_ffra_types::claim_ans_t want;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      wait_cycles = (($urandom_range(0, 9) < 3)) ? 0 : $urandom_range(0, 4);
      if (wait_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result, found", out_ch.found, -1);
      end else begin
        want = pending_answers.pop_front();
        claims_checked++;
        if (want.found) claims_found++;
        if (out_ch.found !== want.found)
          report_mismatch("found", out_ch.found, want.found);
        if (out_ch.start_position !== want.start)
          report_mismatch("start_position", out_ch.start_position, want.start);
      end
    end
  end

  // Drives one item; on acceptance records its load or expected claim answer. Valid stays high
  // after acceptance so that the next item can follow without a gap.
  task automatic send_item(input tb_ffra_types::stim_row_t row);
    tb_ffra_types::claim_ans_t ans;
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 9) < 3) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= row.op;
    in_ch.position       <= row.pos;
    in_ch.bit_kind       <= row.kind;
    in_ch.request_length <= row.len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (row.op == ffra_pkg::OP_LOAD) begin
      shadow_map[row.pos] = row.kind;
    end else begin
      ans = first_fit_claim(row.kind, row.len);
      if (row.fixed && (ans.found !== row.fixed_found || ans.start !== row.fixed_start))
        report_mismatch("predictor vs typed answer", ans.start, row.fixed_start);
      pending_answers.push_back(ans);
    end
  endtask

  // Drops valid, waits for all answers, then for the block to finish a trailing load.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_size(input logic [ffra_pkg::LEN_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow_size = value;
  endtask

  function automatic tb_ffra_types::stim_row_t mk(input logic op, input int pos,
                                                  input logic kind, input int len,
                                                  input bit fixed = 0,
                                                  input logic ff = 0, input int fs = 0);
    tb_ffra_types::stim_row_t r;
    r.op = op; r.pos = ffra_pkg::POS_W'(pos); r.kind = kind;
    r.len = ffra_pkg::LEN_W'(len);
    r.fixed = fixed; r.fixed_found = ff; r.fixed_start = ffra_pkg::POS_W'(fs);
    return r;
  endfunction

  tb_ffra_types::stim_row_t directed[$];

  // Random item: mostly claims with short lengths, loads to fragment the map.
  function automatic tb_ffra_types::stim_row_t random_row();
    tb_ffra_types::stim_row_t r;
    int sel;
    r = mk(ffra_pkg::OP_LOAD, $urandom_range(0, ffra_pkg::MAX_POS - 1),
           1'($urandom_range(0, 1)), 0);
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      r.op = ffra_pkg::OP_CLAIM;
      r.len = ffra_pkg::LEN_W'($urandom_range(1, 12));
    end else if (sel < 52) begin
      r.op = ffra_pkg::OP_CLAIM;
      r.len = ffra_pkg::LEN_W'($urandom_range(0, 2047));
    end else if (sel < 55) begin
      r.op = ffra_pkg::OP_CLAIM;
      r.len = ffra_pkg::LEN_W'($urandom_range(0, 1) ? 0 : 1024);
    end else if (sel < 80) begin
      r.pos = ffra_pkg::POS_W'($urandom_range(0, 63));
    end
    if (r.op == ffra_pkg::OP_LOAD && $urandom_range(0, 1))
      r.len = ffra_pkg::LEN_W'($urandom);
    return r;
  endfunction

  initial begin
    logic [ffra_pkg::LEN_W-1:0] sizes[$];
    errors = 0; claims_checked = 0; claims_found = 0;
    hold_off = 0;
    for (int i = 0; i < ffra_pkg::MAX_POS; i++) shadow_map[i] = 1'b0;
    shadow_size = ffra_pkg::SIZE_RESET;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    in_ch.valid = 1'b0; in_ch.operation = ffra_pkg::OP_LOAD; in_ch.position = '0;
    in_ch.bit_kind = 1'b0; in_ch.request_length = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: extremes, zero-length, too long, lone position.
    directed.push_back(mk(ffra_pkg::OP_CLAIM, 0, 1, 1, 1, 0, 0));
    directed.push_back(mk(ffra_pkg::OP_CLAIM, 0, 0, 0, 1, 0, 0));
    directed.push_back(mk(ffra_pkg::OP_CLAIM, 1023, 0, 1024, 1, 1, 0));
    directed.push_back(mk(ffra_pkg::OP_CLAIM, 0, 0, 1, 1, 0, 0));
    directed.push_back(mk(ffra_pkg::OP_CLAIM, 0, 1, 2047, 1, 0, 0));
    directed.push_back(mk(ffra_pkg::OP_CLAIM, 0, 1, 1023, 1, 1, 0));
    directed.push_back(mk(ffra_pkg::OP_LOAD, 1023, 1, 0));
    directed.push_back(mk(ffra_pkg::OP_CLAIM, 0, 0, 1, 1, 1, 0));
    directed.push_back(mk(ffra_pkg::OP_CLAIM, 0, 0, 2, 1, 1, 1));
    directed.push_back(mk(ffra_pkg::OP_LOAD, 5, 0, 2047));
    directed.push_back(mk(ffra_pkg::OP_LOAD, 6, 0, 0));
    directed.push_back(mk(ffra_pkg::OP_CLAIM, 0, 0, 2));
    directed.push_back(mk(ffra_pkg::OP_CLAIM, 0, 1, 5));
    directed.push_back(mk(ffra_pkg::OP_LOAD, 512, 0, 0));
    directed.push_back(mk(ffra_pkg::OP_CLAIM, 0, 0, 1));
    foreach (directed[i]) send_item(directed[i]);
    drain_block();

    // Single position active, then sizes 0 and 2047, with directed claims and a load beyond the size.
    write_size(ffra_pkg::LEN_W'(1));
    send_item(mk(ffra_pkg::OP_CLAIM, 0, shadow_map[0], 1, 1, 1, 0));
    send_item(mk(ffra_pkg::OP_CLAIM, 0, ~shadow_map[0], 1, 1, 0, 0));
    send_item(mk(ffra_pkg::OP_CLAIM, 0, shadow_map[0], 2, 1, 0, 0));
    send_item(mk(ffra_pkg::OP_LOAD, 700, 1, 0));
    drain_block();
    write_size(ffra_pkg::LEN_W'(0));
    send_item(mk(ffra_pkg::OP_CLAIM, 0, 0, 1, 1, 0, 0));
    send_item(mk(ffra_pkg::OP_CLAIM, 0, 1, 1, 1, 0, 0));
    drain_block();
    write_size(ffra_pkg::LEN_W'(2047));
    send_item(mk(ffra_pkg::OP_CLAIM, 0, 1, 1));
    drain_block();

    // Random part in phases over several sizes; most work at small sizes.
    sizes = '{ffra_pkg::LEN_W'(64), ffra_pkg::LEN_W'(17), ffra_pkg::LEN_W'(1024),
              ffra_pkg::LEN_W'(2), ffra_pkg::LEN_W'(130), ffra_pkg::LEN_W'(1025),
              ffra_pkg::LEN_W'(40)};
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      for (int i = 0; i < N_RANDOM / sizes.size(); i++) begin
        if (p == 0 && i == 40) hold_off = 1;
        send_item(random_row());
      end
      drain_block();
    end

    drain_block();
    repeat (400) @(posedge clk);
    $display("Checked %0d claim results (%0d found) over sizes 0 to 2047.",
             claims_checked, claims_found);
    $display("Random stalls on both sides and one long receiver hold-off were applied.");
    if (errors == 0 && pending_answers.size() == 0)
      $display("** first_fit_run_allocator_core: PASSED **");
    else
      $display("** first_fit_run_allocator_core: FAILED **");
    $finish;
  end
endmodule
